// ===== hdl/asd_pkg.sv =====
// shared types, codes and constants of the step detector
package asd_pkg;

    localparam int HISTORY_DAYS_DEF = 8;

    localparam int STEP_W     = 24;
    localparam int FILL_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ROOT_STEPS = 16;
    localparam int SQ_AXES    = 3;
    localparam int CNT_W      = 4;

    localparam logic [14:0] RISE_RST     = 15'd451;
    localparam logic [14:0] FALL_RST     = 15'd164;
    localparam logic [15:0] INTERVAL_RST = 16'd260;
    localparam logic [23:0] GOAL_RST     = 24'd8000;
    localparam logic [15:0] RATE_RST     = 16'd1311;
    localparam logic [23:0] BASELINE_RST = 24'd1048576;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } asd_func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RISE     = 3'd0,
        REG_FALL     = 3'd1,
        REG_INTERVAL = 3'd2,
        REG_GOAL     = 3'd3,
        REG_RATE     = 3'd4
    } asd_reg_t;

    typedef struct packed {
        logic       load;
        logic       exec;
        logic       sq_step;
        logic [1:0] sq_sel;
        logic       root_step;
        logic       scale;
        logic       update;
        logic       out_load;
    } asd_cmd_t;

    typedef struct packed {
        asd_func_t func;
        logic      sample_valid;
    } asd_status_t;

endpackage

// ===== hdl/asd_ctrl.sv =====
// sequencer of the step detector: one item at a time, output slot flag
module asd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   out_ready,
    input  asd_pkg::asd_status_t   status,
    output logic                   in_ready,
    output logic                   out_valid,
    output asd_pkg::asd_cmd_t      cmd
);
    import asd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SQUARE,
        S_ROOT,
        S_SCALE,
        S_UPDATE,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.sq_sel = cnt_reg[1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                cnt_next = '0;
                if (status.func == FUNC_TICK && status.sample_valid)
                    state_next = S_SQUARE;
                else
                    state_next = S_FINISH;
            end
            S_SQUARE:
            begin
                cmd.sq_step = 1'b1;
                if (cnt_reg == CNT_W'(SQ_AXES - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/asd_datapath.sv =====
// datapath: config registers, magnitude, baseline, step logic, day history
module asd_datapath #(
    parameter int HISTORY_DAYS = asd_pkg::HISTORY_DAYS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [asd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [1:0]                        func,
    input  logic                              sample_valid,
    input  logic signed [15:0]                accel_x,
    input  logic signed [15:0]                accel_y,
    input  logic signed [15:0]                accel_z,
    input  logic [31:0]                       time_ms,
    input  logic signed [17:0]                day_number,
    input  logic [5:0]                        history_index,
    input  asd_pkg::asd_cmd_t                 cmd,
    output asd_pkg::asd_status_t              status,
    output logic [asd_pkg::STEP_W-1:0]        step_count,
    output logic                              step_taken,
    output logic                              goal_reached,
    output logic                              day_closed,
    output logic [asd_pkg::FILL_W-1:0]        history_count,
    output logic [asd_pkg::STEP_W-1:0]        history_value,
    output logic                              history_valid
);
    import asd_pkg::*;

    localparam int AW = (HISTORY_DAYS > 1) ? $clog2(HISTORY_DAYS) : 1;
    localparam logic [FILL_W-1:0] DEPTH   = FILL_W'(HISTORY_DAYS);
    localparam logic [AW-1:0]     LAST    = AW'(HISTORY_DAYS - 1);
    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    // captured item
    asd_func_t          func_reg;
    logic               sv_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [31:0]        time_reg;
    logic signed [17:0] day_reg;
    logic [5:0]         idx_reg;

    // configuration
    logic [14:0] rise_reg, rise_next;
    logic [14:0] fall_reg, fall_next;
    logic [15:0] interval_reg, interval_next;
    logic [23:0] goal_reg, goal_next;
    logic [15:0] rate_reg, rate_next;

    // detector state
    logic [23:0]        baseline_reg, baseline_next;
    logic               armed_reg, armed_next;
    logic [31:0]        last_step_reg, last_step_next;
    logic [STEP_W-1:0]  today_reg, today_next;
    logic               goal_done_reg, goal_done_next;
    logic signed [17:0] cur_day_reg, cur_day_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [AW-1:0]      head_reg, head_next;

    // working registers
    logic [31:0]        ss_reg, res_reg, bit_reg;
    logic signed [41:0] prod_reg;
    logic               st_reg, gr_reg, dc_reg;

    // history store
    logic [STEP_W-1:0]  hist_mem [HISTORY_DAYS];
    logic [STEP_W-1:0]  hist_rd_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [FILL_W-1:0]  rsum;

    // output register
    logic [STEP_W-1:0]  step_count_reg;
    logic               step_taken_reg, goal_reached_reg, day_closed_reg;
    logic [FILL_W-1:0]  history_count_reg;
    logic [STEP_W-1:0]  history_value_reg;
    logic               history_valid_reg;

    // arithmetic
    logic signed [15:0] axis;
    logic signed [31:0] sq_prod;
    logic [31:0]        trial;
    logic [23:0]        mag_q20;
    logic signed [24:0] diff;
    logic signed [41:0] prod_w;
    logic signed [25:0] delta;
    logic signed [26:0] nb;
    logic [23:0]        nb_clamp;
    logic signed [25:0] dev, rise_q, fall_q;
    logic [31:0]        elapsed;
    logic [STEP_W-1:0]  today_inc;
    logic               fill_lt, hist_hit;

    always_comb
    begin
        case (cmd.sq_sel)
            2'd0:    axis = ax_reg;
            2'd1:    axis = ay_reg;
            default: axis = az_reg;
        endcase
        sq_prod = axis * axis;
        trial   = res_reg + bit_reg;

        mag_q20  = {res_reg[15:0], 8'h00};
        diff     = $signed({1'b0, mag_q20}) - $signed({1'b0, baseline_reg});
        prod_w   = diff * $signed({1'b0, rate_reg});
        // floor of the product over 2^16
        delta    = prod_reg[41:16];
        nb       = $signed({3'b000, baseline_reg}) + $signed({delta[25], delta});
        if (nb[26])
            nb_clamp = '0;
        else if (nb[25:24] != 2'b00)
            nb_clamp = 24'hFF_FFFF;
        else
            nb_clamp = nb[23:0];
        dev      = $signed({2'b00, mag_q20}) - $signed({2'b00, nb_clamp});
        rise_q   = $signed({3'b000, rise_reg, 8'h00});
        fall_q   = $signed({3'b000, fall_reg, 8'h00});
        elapsed  = time_reg - last_step_reg;
        today_inc = (today_reg == STEP_MAX) ? today_reg : today_reg + 1'b1;

        fill_lt   = (fill_reg < DEPTH);
        mem_waddr = fill_lt ? fill_reg[AW-1:0] : head_reg;
        rsum      = FILL_W'(head_reg) + FILL_W'(idx_reg);
        mem_raddr = (rsum >= DEPTH) ? AW'(rsum - DEPTH) : rsum[AW-1:0];
        hist_hit  = ({1'b0, idx_reg} < fill_reg);
    end

    // next state of configuration and detector
    always_comb
    begin
        rise_next      = rise_reg;
        fall_next      = fall_reg;
        interval_next  = interval_reg;
        goal_next      = goal_reg;
        rate_next      = rate_reg;
        baseline_next  = baseline_reg;
        armed_next     = armed_reg;
        last_step_next = last_step_reg;
        today_next     = today_reg;
        goal_done_next = goal_done_reg;
        cur_day_next   = cur_day_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        mem_we         = 1'b0;

        if (cfg_write)
        begin
            case (asd_reg_t'(cfg_index))
                REG_RISE:     rise_next     = cfg_data[14:0];
                REG_FALL:     fall_next     = cfg_data[14:0];
                REG_INTERVAL: interval_next = cfg_data[15:0];
                REG_GOAL:
                begin
                    goal_next      = cfg_data[23:0];
                    goal_done_next = (cfg_data[23:0] != '0) && (today_reg >= cfg_data[23:0]);
                end
                REG_RATE:     rate_next     = cfg_data[15:0];
                default:      ;
            endcase
        end

        if (cmd.exec)
        begin
            case (func_reg)
                FUNC_TICK:
                begin
                    if (!day_reg[17])
                    begin
                        if (cur_day_reg[17])
                            cur_day_next = day_reg;
                        else if (day_reg != cur_day_reg)
                        begin
                            // close the day: append, or overwrite the oldest
                            mem_we         = 1'b1;
                            today_next     = '0;
                            goal_done_next = 1'b0;
                            cur_day_next   = day_reg;
                            if (fill_lt)
                                fill_next = fill_reg + 1'b1;
                            else
                                head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
                        end
                    end
                end
                FUNC_CLEAR:
                begin
                    today_next     = '0;
                    armed_next     = 1'b0;
                    goal_done_next = 1'b0;
                end
                default: ;
            endcase
        end

        if (cmd.update)
        begin
            baseline_next = nb_clamp;
            if (!armed_reg && (dev > rise_q))
            begin
                armed_next = 1'b1;
                if (elapsed >= {16'h0000, interval_reg})
                begin
                    today_next     = today_inc;
                    last_step_next = time_reg;
                    if ((goal_reg != '0) && !goal_done_reg && (today_inc >= goal_reg))
                        goal_done_next = 1'b1;
                end
            end
            else if (armed_reg && (dev < fall_q))
                armed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_reg      <= RISE_RST;
            fall_reg      <= FALL_RST;
            interval_reg  <= INTERVAL_RST;
            goal_reg      <= GOAL_RST;
            rate_reg      <= RATE_RST;
            baseline_reg  <= BASELINE_RST;
            armed_reg     <= 1'b0;
            last_step_reg <= '0;
            today_reg     <= '0;
            goal_done_reg <= 1'b0;
            cur_day_reg   <= '1;
            fill_reg      <= '0;
            head_reg      <= '0;
        end
        else
        begin
            rise_reg      <= rise_next;
            fall_reg      <= fall_next;
            interval_reg  <= interval_next;
            goal_reg      <= goal_next;
            rate_reg      <= rate_next;
            baseline_reg  <= baseline_next;
            armed_reg     <= armed_next;
            last_step_reg <= last_step_next;
            today_reg     <= today_next;
            goal_done_reg <= goal_done_next;
            cur_day_reg   <= cur_day_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
        end
    end

    // item capture, iteration registers, result flags
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= asd_func_t'(func);
            sv_reg   <= sample_valid;
            ax_reg   <= accel_x;
            ay_reg   <= accel_y;
            az_reg   <= accel_z;
            time_reg <= time_ms;
            day_reg  <= day_number;
            idx_reg  <= history_index;
            ss_reg   <= '0;
            res_reg  <= '0;
            bit_reg  <= 32'h4000_0000;
            st_reg   <= 1'b0;
            gr_reg   <= 1'b0;
            dc_reg   <= 1'b0;
        end
        if (cmd.exec && mem_we)
            dc_reg <= 1'b1;
        if (cmd.sq_step)
            ss_reg <= ss_reg + 32'(unsigned'(sq_prod));
        if (cmd.root_step)
        begin
            // one result bit per step, remainder kept in ss_reg
            if (ss_reg >= trial)
            begin
                ss_reg  <= ss_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.scale)
            prod_reg <= prod_w;
        if (cmd.update && !armed_reg && (dev > rise_q) &&
            (elapsed >= {16'h0000, interval_reg}))
        begin
            st_reg <= 1'b1;
            gr_reg <= (goal_reg != '0) && !goal_done_reg && (today_inc >= goal_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[mem_waddr] <= today_reg;
        hist_rd_reg <= hist_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            step_count_reg    <= today_reg;
            step_taken_reg    <= st_reg;
            goal_reached_reg  <= gr_reg;
            day_closed_reg    <= dc_reg;
            history_count_reg <= fill_reg;
            if (func_reg == FUNC_READ && hist_hit)
            begin
                history_value_reg <= hist_rd_reg;
                history_valid_reg <= 1'b1;
            end
            else
            begin
                history_value_reg <= '0;
                history_valid_reg <= 1'b0;
            end
        end
    end

    assign status.func         = func_reg;
    assign status.sample_valid = sv_reg;

    assign step_count    = step_count_reg;
    assign step_taken    = step_taken_reg;
    assign goal_reached  = goal_reached_reg;
    assign day_closed    = day_closed_reg;
    assign history_count = history_count_reg;
    assign history_value = history_value_reg;
    assign history_valid = history_valid_reg;

endmodule

// ===== hdl/accel_step_detector.sv =====
// top level of the threshold step detector with daily step history
//
// channel   signals                                   direction
// ------    ---------------------------------------   ---------
// input     in_valid / in_ready + item fields         in
// output    out_valid / out_ready + result fields     out
// config    cfg_write, cfg_index, cfg_data            in, no wait
//
// a sample tick with a sample runs from one input transfer to the
// next through capture, day check, 3 squaring steps on one 16x16 multiplier,
// 16 steps of the bit-pair square root, one 25x17 scaling multiply, update
// and hand-off; the square root loop is the longest of these
// any other item skips the squaring, root, scaling and update; one item is worked on at a time
// the result sits in an output register, so the next input transfer is
// taken while an earlier result still waits on out_ready
// reset is asynchronous and active low; the history store is not cleared
module accel_step_detector #(
    parameter int HISTORY_DAYS = asd_pkg::HISTORY_DAYS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_write,
    input  logic [asd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        func,
    input  logic                              sample_valid,
    input  logic signed [15:0]                accel_x,
    input  logic signed [15:0]                accel_y,
    input  logic signed [15:0]                accel_z,
    input  logic [31:0]                       time_ms,
    input  logic signed [17:0]                day_number,
    input  logic [5:0]                        history_index,
    // result items
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [asd_pkg::STEP_W-1:0]        step_count,
    output logic                              step_taken,
    output logic                              goal_reached,
    output logic                              day_closed,
    output logic [asd_pkg::FILL_W-1:0]        history_count,
    output logic [asd_pkg::STEP_W-1:0]        history_value,
    output logic                              history_valid
);
    import asd_pkg::*;

    // command and status between sequencer and datapath
    asd_cmd_t    cmd;
    asd_status_t status;

    // sequencer: walks each item through its steps, owns the output slot flag
    asd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // datapath: settings, magnitude and baseline, step counting, history ring
    asd_datapath #(
        .HISTORY_DAYS (HISTORY_DAYS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .sample_valid  (sample_valid),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .time_ms       (time_ms),
        .day_number    (day_number),
        .history_index (history_index),
        .cmd           (cmd),
        .status        (status),
        .step_count    (step_count),
        .step_taken    (step_taken),
        .goal_reached  (goal_reached),
        .day_closed    (day_closed),
        .history_count (history_count),
        .history_value (history_value),
        .history_valid (history_valid)
    );

    // an input transfer closes the input side until the item is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in progress");

    // the history never holds more days than it has room for
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (history_count <= FILL_W'(HISTORY_DAYS)))
        else $error("history count beyond depth");

    // the goal pulse only comes with a counted step
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && goal_reached) |-> (step_taken && (step_count != '0)))
        else $error("goal pulse without a step");

    // a freshly closed day leaves at most the one step of this tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && day_closed) |-> (step_count <= STEP_W'(1)))
        else $error("count not cleared when the day closed");

endmodule

// ===== sim/asd_result_check.sv =====
// result checker of the step detector: predicts every transfer and compares results
module asd_result_check #(
    parameter int HISTORY_DAYS = asd_pkg::HISTORY_DAYS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [asd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [1:0]                     func,
    input  logic                           sample_valid,
    input  logic signed [15:0]             accel_x,
    input  logic signed [15:0]             accel_y,
    input  logic signed [15:0]             accel_z,
    input  logic [31:0]                    time_ms,
    input  logic signed [17:0]             day_number,
    input  logic [5:0]                     history_index,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [asd_pkg::STEP_W-1:0]     step_count,
    input  logic                           step_taken,
    input  logic                           goal_reached,
    input  logic                           day_closed,
    input  logic [asd_pkg::FILL_W-1:0]     history_count,
    input  logic [asd_pkg::STEP_W-1:0]     history_value,
    input  logic                           history_valid,
    output int                             fail_count,
    output int                             pending,
    output int                             results_checked,
    output int                             steps_counted,
    output int                             goal_pulses,
    output int                             day_closes
);
    timeunit 1ns;
    timeprecision 1ps;

    import asd_pkg::*;

    localparam longint STEP_MAX    = (64'sd1 <<< STEP_W) - 1;

    typedef struct packed {
        logic [STEP_W-1:0] count;
        logic              taken;
        logic              goal;
        logic              closed;
        logic [FILL_W-1:0] fill;
        logic [STEP_W-1:0] hval;
        logic              hvalid;
    } step_result_t;

    // register copies
    logic [14:0]       rise_thr;
    logic [14:0]       fall_thr;
    logic [15:0]       min_gap_ms;
    logic [STEP_W-1:0] daily_goal;
    logic [15:0]       track_gain;

    // detector state
    logic [23:0]        baseline_q20;
    logic               armed;
    logic [31:0]        last_step_ms;
    logic [STEP_W-1:0]  steps_today;
    logic               goal_met;
    logic signed [17:0] cur_day;
    logic [STEP_W-1:0]  day_log [HISTORY_DAYS];
    int unsigned        log_fill;

    step_result_t expected_q[$];
    int           mismatch_total;
    int           checked_total;
    int           step_total;
    int           goal_total;
    int           close_total;

    task automatic report_mismatch(string what);
        mismatch_total++;
        $display("%0t ns  result %0d: %s", $time, checked_total, what);
    endtask

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want !== got)
            report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // works out the result of the item at the input transfer and moves the state on
    function automatic step_result_t predict_item();
        step_result_t r;
        longint       sq_sum;
        longint       mag;
        longint       delta;
        longint       nb;
        longint       dev;
        logic [31:0]  since_last;
        r = '0;
        case (asd_func_t'(func))
            FUNC_TICK: begin
                if (!day_number[17]) begin
                    if (cur_day[17]) begin
                        cur_day = day_number;
                    end
                    else if (day_number != cur_day) begin
                        // shift today into history, oldest drops out when full
                        if (log_fill < HISTORY_DAYS) begin
                            day_log[log_fill] = steps_today;
                            log_fill++;
                        end
                        else begin
                            for (int i = 1; i < HISTORY_DAYS; i++)
                                day_log[i-1] = day_log[i];
                            day_log[HISTORY_DAYS-1] = steps_today;
                        end
                        steps_today = '0;
                        goal_met    = 1'b0;
                        cur_day     = day_number;
                        r.closed    = 1'b1;
                    end
                end
                if (sample_valid) begin
                    sq_sum = longint'(accel_x) * accel_x + longint'(accel_y) * accel_y
                           + longint'(accel_z) * accel_z;
                    mag   = longint'(floor_sqrt(sq_sum)) * 256;
                    // arithmetic shift floors toward minus infinity
                    delta = ((mag - longint'(baseline_q20)) * longint'(track_gain)) >>> 16;
                    nb    = longint'(baseline_q20) + delta;
                    if (nb < 0)
                        nb = 0;
                    else if (nb > STEP_MAX)
                        nb = STEP_MAX;
                    baseline_q20 = nb[23:0];
                    dev = mag - longint'(baseline_q20);
                    if (!armed && dev > longint'(rise_thr) * 256) begin
                        armed      = 1'b1;
                        since_last = time_ms - last_step_ms;
                        if (since_last >= min_gap_ms) begin
                            if (steps_today != '1)
                                steps_today++;
                            last_step_ms = time_ms;
                            r.taken      = 1'b1;
                            if (daily_goal != 0 && !goal_met && steps_today >= daily_goal) begin
                                goal_met = 1'b1;
                                r.goal   = 1'b1;
                            end
                        end
                    end
                    else if (armed && dev < longint'(fall_thr) * 256) begin
                        armed = 1'b0;
                    end
                end
            end
            FUNC_CLEAR: begin
                steps_today = '0;
                armed       = 1'b0;
                goal_met    = 1'b0;
            end
            FUNC_READ: begin
                if (history_index < log_fill) begin
                    r.hval   = day_log[history_index];
                    r.hvalid = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = steps_today;
        r.fill  = log_fill[FILL_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        step_result_t want;
        if (!rst_n) begin
            rise_thr     = RISE_RST;
            fall_thr     = FALL_RST;
            min_gap_ms   = INTERVAL_RST;
            daily_goal   = GOAL_RST;
            track_gain   = RATE_RST;
            baseline_q20 = BASELINE_RST;
            armed        = 1'b0;
            last_step_ms = '0;
            steps_today  = '0;
            goal_met     = 1'b0;
            cur_day      = -18'sd1;
            log_fill     = 0;
            expected_q.delete();
            mismatch_total = 0;
            checked_total  = 0;
            step_total     = 0;
            goal_total     = 0;
            close_total    = 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_RISE:     rise_thr   = cfg_data[14:0];
                    REG_FALL:     fall_thr   = cfg_data[14:0];
                    REG_INTERVAL: min_gap_ms = cfg_data[15:0];
                    REG_GOAL: begin
                        daily_goal = cfg_data[STEP_W-1:0];
                        goal_met   = (daily_goal != 0) && (steps_today >= daily_goal);
                    end
                    REG_RATE:     track_gain = cfg_data[15:0];
                    default: ;
                endcase
            end
            // results first, an item taken at this edge cannot have come out yet
            if (out_valid && out_ready) begin
                checked_total++;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending, step_count %0d",
                                              step_count));
                end
                else begin
                    want = expected_q.pop_front();
                    compare_field("step_count",    want.count,  step_count);
                    compare_field("step_taken",    want.taken,  step_taken);
                    compare_field("goal_reached",  want.goal,   goal_reached);
                    compare_field("day_closed",    want.closed, day_closed);
                    compare_field("history_count", want.fill,   history_count);
                    compare_field("history_value", want.hval,   history_value);
                    compare_field("history_valid", want.hvalid, history_valid);
                end
            end
            if (in_valid && in_ready) begin
                want = predict_item();
                step_total  += want.taken;
                goal_total  += want.goal;
                close_total += want.closed;
                expected_q.push_back(want);
            end
        end
        fail_count      <= mismatch_total;
        pending         <= expected_q.size();
        results_checked <= checked_total;
        steps_counted   <= step_total;
        goal_pulses     <= goal_total;
        day_closes      <= close_total;
    end

endmodule

// ===== sim/accel_step_detector_tb.sv =====
// testbench top of the step detector: stimulus, flow control, watchdog and verdict
module accel_step_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asd_pkg::*;

    localparam int HISTORY_DAYS    = HISTORY_DAYS_DEF;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 238;
    localparam int HOLD_OFF_CYCLES = 300;
    // a quiet stretch far longer than the slowest correct transfer gap
    localparam int QUIET_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct {
        asd_func_t          op;
        logic               smp;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [31:0]        ms;
        logic signed [17:0] day;
        logic [5:0]         hidx;
    } sensor_item_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               func;
    logic                     sample_valid;
    logic signed [15:0]       accel_x;
    logic signed [15:0]       accel_y;
    logic signed [15:0]       accel_z;
    logic [31:0]              time_ms;
    logic signed [17:0]       day_number;
    logic [5:0]               history_index;
    logic                     out_valid;
    logic                     out_ready;
    logic [STEP_W-1:0]        step_count;
    logic                     step_taken;
    logic                     goal_reached;
    logic                     day_closed;
    logic [FILL_W-1:0]        history_count;
    logic [STEP_W-1:0]        history_value;
    logic                     history_valid;

    int chk_fail_count;
    int chk_pending;
    int chk_results;
    int chk_steps;
    int chk_goals;
    int chk_closes;

    // flow control knobs, idle_pct only used by the sender process
    int   idle_pct;
    int   stall_pct;
    logic hold_off_req;
    logic hold_off_done;
    int   items_sent;
    int   settings_used;

    // walking pattern state: running clock and calendar day
    logic [31:0] gait_ms;
    int          gait_day;

    sensor_item_t opening[$];

    accel_step_detector #(
        .HISTORY_DAYS(HISTORY_DAYS)
    ) dut (
        .*
    );

    asd_result_check #(
        .HISTORY_DAYS(HISTORY_DAYS)
    ) result_check (
        .*,
        .fail_count     (chk_fail_count),
        .pending        (chk_pending),
        .results_checked(chk_results),
        .steps_counted  (chk_steps),
        .goal_pulses    (chk_goals),
        .day_closes     (chk_closes)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // tick item, history index random since the block ignores it here
    function automatic sensor_item_t make_tick(logic smp, int ax, int ay, int az,
                                               logic [31:0] ms, int day);
        sensor_item_t it;
        it.op   = FUNC_TICK;
        it.smp  = smp;
        it.ax   = 16'(ax);
        it.ay   = 16'(ay);
        it.az   = 16'(az);
        it.ms   = ms;
        it.day  = 18'(day);
        it.hidx = 6'($urandom_range(63));
        return it;
    endfunction

    // non tick item, the sample fields carry junk that must be ignored
    function automatic sensor_item_t make_op(asd_func_t op, int hidx);
        sensor_item_t it;
        it      = make_tick(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
                            $urandom_range(131071));
        it.op   = op;
        it.hidx = 6'(hidx);
        return it;
    endfunction

    // mostly well formed walking: ~1 g with a stride peak now and then, time moving
    // forward by a sample period; the rest are clears, history reads and pure noise
    function automatic sensor_item_t gait_item();
        sensor_item_t it;
        int           roll;
        int           g;
        roll = $urandom_range(99);
        it   = make_op(FUNC_TICK, $urandom_range(63));
        if (roll < 1) begin
            it.op = FUNC_CLEAR;
        end
        else if (roll < 7) begin
            it.op   = FUNC_READ;
            // bias reads toward the populated part of the history
            it.hidx = 6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(9));
        end
        else if (roll < 8) begin
            it.op = FUNC_NONE;
        end
        else if (roll < 20) begin
            // noise tick: full range axes and time, day mostly sane
            case ($urandom_range(9))
                0:       it.day = 18'($urandom_range(131071));
                1, 2, 3: it.day = -18'sd1;
                default: it.day = 18'(gait_day);
            endcase
        end
        else begin
            gait_ms += $urandom_range(20, 45);
            if ($urandom_range(149) == 0)
                gait_day++;
            it.ms  = gait_ms;
            it.day = ($urandom_range(39) == 0) ? -18'sd1 : 18'(gait_day);
            it.smp = ($urandom_range(19) != 0);
            g = ($urandom_range(7) == 0) ? $urandom_range(4900, 6600) : $urandom_range(3700, 4300);
            it.ax = 16'(int'($urandom_range(800)) - 400);
            it.ay = 16'(int'($urandom_range(800)) - 400);
            it.az = 16'(g);
            // device held sideways now and then
            if ($urandom_range(3) == 0) begin
                it.ax = 16'(-g);
                it.az = 16'(int'($urandom_range(800)) - 400);
            end
        end
        return it;
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input sensor_item_t it);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= it.op;
        sample_valid  <= it.smp;
        accel_x       <= it.ax;
        accel_y       <= it.ay;
        accel_z       <= it.az;
        time_ms       <= it.ms;
        day_number    <= it.day;
        history_index <= it.hidx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // wait until every expected result has come back
    task automatic drain();
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
    endtask

    // writes all five registers on consecutive cycles, write enable held high
    task automatic load_settings(logic [14:0] rise, logic [14:0] fall, logic [15:0] gap,
                                 logic [23:0] goal, logic [15:0] gain);
        cfg_write <= 1'b1;
        cfg_index <= REG_RISE;
        cfg_data  <= CFG_DATA_W'(rise);
        @(posedge clk);
        cfg_index <= REG_FALL;
        cfg_data  <= CFG_DATA_W'(fall);
        @(posedge clk);
        cfg_index <= REG_INTERVAL;
        cfg_data  <= CFG_DATA_W'(gap);
        @(posedge clk);
        cfg_index <= REG_GOAL;
        cfg_data  <= CFG_DATA_W'(goal);
        @(posedge clk);
        cfg_index <= REG_RATE;
        cfg_data  <= CFG_DATA_W'(gain);
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // receiver: random stalls, plus one long hold-off so the block backs up
    initial
    begin
        out_ready     <= 1'b0;
        hold_off_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: any transfer or register write restarts the quiet count
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d results still pending",
                 QUIET_LIMIT, chk_pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        // every input known from time zero, reset held low at the start
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= REG_RISE;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        func          <= FUNC_TICK;
        sample_valid  <= 1'b0;
        accel_x       <= '0;
        accel_y       <= '0;
        accel_z       <= '0;
        time_ms       <= '0;
        day_number    <= '0;
        history_index <= '0;
        idle_pct       = 0;
        stall_pct     <= 0;
        hold_off_req  <= 1'b0;
        items_sent     = 0;
        settings_used  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: reset thresholds with a goal of three steps
        load_settings(RISE_RST, FALL_RST, INTERVAL_RST, 24'd3, RATE_RST);
        // clock not set, no sample, then a sample with no day
        opening.push_back(make_tick(1'b0, 0, 0, 0, 0, -1));
        opening.push_back(make_tick(1'b1, 0, 0, 4096, 100, -1));
        // first valid day is taken over, the 1.3 g peak counts a step
        opening.push_back(make_tick(1'b1, 0, 0, 5325, 500, 5));
        opening.push_back(make_tick(1'b1, 0, 0, 4096, 530, 5));
        // rearmed but too soon after the last step
        opening.push_back(make_tick(1'b1, 0, 0, 5325, 600, 5));
        opening.push_back(make_tick(1'b1, 0, 0, 4096, 630, 5));
        opening.push_back(make_tick(1'b1, 0, 0, 5325, 900, 5));
        opening.push_back(make_tick(1'b1, 0, 0, 4096, 930, 5));
        // third step reaches the goal, the fourth must not pulse again
        opening.push_back(make_tick(1'b1, 0, 0, 5325, 1300, 5));
        opening.push_back(make_tick(1'b1, 0, 0, 4096, 1330, 5));
        opening.push_back(make_tick(1'b1, 0, 0, 5325, 1700, 5));
        // day change without a sample closes day 5
        opening.push_back(make_tick(1'b0, 0, 0, 4096, 1730, 6));
        // history hit, out of range index, index at the fill level
        opening.push_back(make_op(FUNC_READ, 0));
        opening.push_back(make_op(FUNC_READ, 63));
        opening.push_back(make_op(FUNC_READ, 1));
        opening.push_back(make_op(FUNC_CLEAR, 0));
        opening.push_back(make_op(FUNC_NONE, 0));
        // largest magnitudes, top of the day range, time near the wrap
        opening.push_back(make_tick(1'b1, -32768, -32768, -32768, 32'hFFFF_FFF0, 131071));
        opening.push_back(make_tick(1'b1, 32767, 32767, 32767, 32'hFFFF_FFFF, 131071));
        // zero magnitude drags the baseline down, day 0 closes the previous one
        opening.push_back(make_tick(1'b1, 0, 0, 0, 32'h0000_0010, 0));
        // step interval measured across the time wrap
        opening.push_back(make_tick(1'b1, 0, 0, 32767, 32'h0000_0200, 0));
        opening.push_back(make_tick(1'b1, -1, 1, -4096, 32'h0000_0220, 0));
        opening.push_back(make_op(FUNC_READ, 2));
        foreach (opening[i])
            send_item(opening[i]);
        in_valid <= 1'b0;
        drain();

        gait_ms  = $urandom;
        gait_day = $urandom_range(100000);
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // registers only change with the block idle
            case (p)
                0: load_settings(RISE_RST, FALL_RST, INTERVAL_RST, 24'd8, RATE_RST);
                1: load_settings('0, '0, '0, '0, '0);
                2: load_settings('1, '1, '1, '1, '1);
                3: load_settings(15'($urandom_range(200, 1500)), 15'($urandom_range(0, 200)),
                                 16'($urandom_range(0, 600)), 24'($urandom_range(1, 15)),
                                 16'($urandom_range(500, 8000)));
                4: load_settings(15'($urandom_range(32767)), 15'($urandom_range(32767)),
                                 16'($urandom_range(65535)), 24'($urandom_range(1, 20)),
                                 16'($urandom_range(65535)));
                default: load_settings(RISE_RST, FALL_RST, INTERVAL_RST, 24'd1, RATE_RST);
            endcase
            // idling mix rotates: none, sender, receiver, both lightly
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 69; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 69; end
                default: begin idle_pct = 11; stall_pct <= 11; end
            endcase
            // one long receiver hold-off while the sender keeps pushing
            if (p == 4)
                hold_off_req <= 1'b1;
            // near the time wrap in some phases
            if (p % 2 == 1)
                gait_ms = 32'hFFFF_FFFF - $urandom_range(20000);
            repeat (ITEMS_PER_PHASE)
                send_item(gait_item());
            in_valid <= 1'b0;
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d items under %0d register settings, %0d results checked",
                 items_sent, settings_used, chk_results);
        $display("predicted %0d steps, %0d goal pulses and %0d day closures",
                 chk_steps, chk_goals, chk_closes);
        if (chk_fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
